>>> design/dst3_pkg.sv
// ----------------------------------------------------------------------------
// dst3_pkg
// Shared types and constants of the seven-point 3D diffusion stencil.
// ----------------------------------------------------------------------------
package dst3_pkg;

  localparam int ROW_LEN_DEF  = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int DATA_W    = 32;
  localparam int NUM_COEF  = 7;
  localparam int ROWS_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int Q_FRAC    = 30;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // Register indexes of the configuration port; coefficient slots share them
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_C = 3'd0,
    CFG_COEF_E = 3'd1,
    CFG_COEF_W = 3'd2,
    CFG_COEF_N = 3'd3,
    CFG_COEF_S = 3'd4,
    CFG_COEF_T = 3'd5,
    CFG_COEF_B = 3'd6,
    CFG_ROWS   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Command flags passed from the front end to the datapath
  typedef struct packed {
    logic wr;       // write the sample into the store
    logic res;      // the command yields a result
    logic cplane;   // plane holding the centre voxel
    logic has_top;  // top neighbor is the incoming sample
    logic has_bot;  // bottom neighbor comes from the other plane
    logic last;     // final result of the sweep
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

>>> design/dst3_ram.sv
// ----------------------------------------------------------------------------
// dst3_ram
// Generic RAM: one write port, two read ports, registered read-first data.
// ----------------------------------------------------------------------------
module dst3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]                      rdata_a_o,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                      rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

>>> design/dst3_fifo.sv
// ----------------------------------------------------------------------------
// dst3_fifo
// Small register queue with ready/valid on both sides.
// ----------------------------------------------------------------------------
module dst3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q < CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/dst3_front.sv
// ----------------------------------------------------------------------------
// dst3_front
// Front end: accepts items, tracks raster position and volume state, and
// issues one datapath command per item that does work.
// ----------------------------------------------------------------------------
module dst3_front
  import dst3_pkg::*;
#(
  parameter int ROW_LEN  = ROW_LEN_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ROWS_W-1:0]                     rows_cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  op_e                                   in_op_i,
  input  logic [DATA_W-1:0]                     in_sample_i,
  input  logic                                  in_last_i,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_ready_i,
  output cmd_ctrl_t                             cmd_ctrl_o,
  output logic [$clog2(ROW_LEN)-1:0]            cmd_x_o,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] cmd_y_o,
  output logic [$clog2(MAX_ROWS + 1)-1:0]       cmd_rows_o,
  output logic [DATA_W-1:0]                     cmd_value_o
);

  localparam int XW  = $clog2(ROW_LEN);
  localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = (RW > ROWS_W) ? RW : ROWS_W;
  localparam int PCW = $clog2(ROW_LEN * MAX_ROWS + 1);

  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;
  logic [1:0]     seen_q, seen_d;
  logic [PCW-1:0] pend_q, pend_d;
  logic           drain_q, drain_d;
  logic           par_q, par_d;

  logic [CW-1:0]  rcfg;
  logic [RW-1:0]  rows_eff;
  logic [YW-1:0]  y;
  logic           col_last, row_last, plane_end, accept;
  logic [XW-1:0]  col_nxt;
  logic [YW-1:0]  row_nxt;
  cmd_ctrl_t      ctrl;

  assign accept     = in_valid_i && cmd_ready_i;
  assign in_ready_o = cmd_ready_i;

  always_comb begin
    rcfg = CW'(rows_cfg_i);
    if (rcfg == '0) begin
      rows_eff = RW'(1);
    end else if (rcfg > CW'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rcfg);
    end
  end

  // Clamp the row when the grid shrank under the current position
  assign y         = (RW'(row_q) >= rows_eff) ? YW'(rows_eff - RW'(1)) : row_q;
  assign col_last  = (col_q == XW'(ROW_LEN - 1));
  assign row_last  = ((RW'(y) + RW'(1)) >= rows_eff);
  assign plane_end = col_last && row_last;
  assign col_nxt   = col_last ? '0 : col_q + XW'(1);
  assign row_nxt   = col_last ? (row_last ? '0 : y + YW'(1)) : y;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    seen_d      = seen_q;
    pend_d      = pend_q;
    drain_d     = drain_q;
    par_d       = par_q;
    cmd_valid_o = 1'b0;
    ctrl        = '0;
    if (accept) begin
      row_d = y;
      case (in_op_i)
        OP_PUSH: begin
          if (!drain_q) begin
            cmd_valid_o  = 1'b1;
            ctrl.wr      = 1'b1;
            ctrl.res     = (seen_q != 2'd0);
            ctrl.cplane  = ~par_q;
            ctrl.has_top = 1'b1;
            ctrl.has_bot = seen_q[1];
            col_d        = col_nxt;
            row_d        = row_nxt;
            if (plane_end) begin
              if (in_last_i) begin
                drain_d = 1'b1;
                pend_d  = PCW'(rows_eff * ROW_LEN);
              end else begin
                if (!seen_q[1]) begin
                  seen_d = seen_q + 2'd1;
                end
                par_d = ~par_q;
              end
            end
          end
        end
        OP_DRAIN: begin
          if (drain_q && (pend_q != '0)) begin
            cmd_valid_o  = 1'b1;
            ctrl.res     = 1'b1;
            ctrl.cplane  = par_q;
            ctrl.has_bot = (seen_q != 2'd0);
            pend_d       = pend_q - PCW'(1);
            col_d        = col_nxt;
            row_d        = row_nxt;
            if (plane_end || (pend_d == '0)) begin
              // close the sweep and get ready for the next volume
              ctrl.last = 1'b1;
              drain_d   = 1'b0;
              pend_d    = '0;
              seen_d    = 2'd0;
              par_d     = 1'b0;
              col_d     = '0;
              row_d     = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_ctrl_o  = ctrl;
  assign cmd_x_o     = col_q;
  assign cmd_y_o     = y;
  assign cmd_rows_o  = rows_eff;
  assign cmd_value_o = in_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      seen_q  <= 2'd0;
      pend_q  <= '0;
      drain_q <= 1'b0;
      par_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      seen_q  <= seen_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
      par_q   <= par_d;
    end
  end

endmodule

>>> design/dst3_back.sv
// ----------------------------------------------------------------------------
// dst3_back
// Datapath: banked plane store, seven multiplies with rounding, saturating
// sum, and the output queue.
// ----------------------------------------------------------------------------
module dst3_back
  import dst3_pkg::*;
#(
  parameter int ROW_LEN  = ROW_LEN_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [DATA_W-1:0]              coef_i [NUM_COEF],
  input  logic                                  cmd_valid_i,
  output logic                                  cmd_ready_o,
  input  cmd_ctrl_t                             cmd_ctrl_i,
  input  logic [$clog2(ROW_LEN)-1:0]            cmd_x_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] cmd_y_i,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]       cmd_rows_i,
  input  logic [DATA_W-1:0]                     cmd_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [DATA_W-1:0]                     out_value_o,
  output logic                                  out_last_o
);

  localparam int XW     = $clog2(ROW_LEN);
  localparam int YW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int HALF   = (ROW_LEN + 1) / 2;
  localparam int GROUPS = (MAX_ROWS + 2) / 3;
  localparam int BDEPTH = GROUPS * HALF;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CRW    = $clog2(OUT_DEPTH + 1);
  localparam int RNDW   = DATA_W + 2;
  localparam int PRW    = RNDW + 1;
  localparam int TOTW   = RNDW + 3;

  // Rows are split over three banks by row mod 3, columns over two by parity
  function automatic logic [YW-1:0] div3(input logic [YW-1:0] v);
    logic [YW+10:0] p;
    p = (YW + 11)'(v) * (YW + 11)'(683);
    return p[YW+10:11];
  endfunction

  function automatic logic [AW-1:0] baddr(input logic [YW-1:0] d, input logic [XW-1:0] xx);
    return AW'(d * HALF + (xx >> 1));
  endfunction

  // ---------------- issue
  logic [CRW-1:0] credit_q, credit_d;
  logic           issue, out_fire;
  logic [YW-1:0]  ydiv, ndiv, sdiv;
  logic [1:0]     ymod, nmod, smod;
  logic [XW-1:0]  xe, xw;
  logic [AW-1:0]  a_c, a_e, a_w, a_n, a_s;
  logic           xpar;

  assign cmd_ready_o = !cmd_ctrl_i.res || (credit_q < CRW'(OUT_DEPTH));
  assign issue       = cmd_valid_i && cmd_ready_o;

  always_comb begin
    ydiv = div3(cmd_y_i);
    ymod = 2'(cmd_y_i - YW'(ydiv * 3));
    nmod = (ymod == 2'd0) ? 2'd2 : ymod - 2'd1;
    ndiv = (ymod == 2'd0) ? ydiv - YW'(1) : ydiv;
    smod = (ymod == 2'd2) ? 2'd0 : ymod + 2'd1;
    sdiv = (ymod == 2'd2) ? ydiv + YW'(1) : ydiv;
  end

  assign xpar = cmd_x_i[0];
  assign xe   = cmd_x_i + XW'(1);
  assign xw   = cmd_x_i - XW'(1);
  assign a_c  = baddr(ydiv, cmd_x_i);
  assign a_e  = baddr(ydiv, xe);
  assign a_w  = baddr(ydiv, xw);
  assign a_n  = baddr(ndiv, cmd_x_i);
  assign a_s  = baddr(sdiv, cmd_x_i);

  logic [DATA_W-1:0] rd_a [2][3][2];
  logic [DATA_W-1:0] rd_b [2][3][2];

  for (genvar p = 0; p < 2; p++) begin : g_plane
    for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 2; c++) begin : g_col
        logic          in_cp, row_y, col_x;
        logic [AW-1:0] ra;
        logic          we;

        assign in_cp = (cmd_ctrl_i.cplane == 1'(p));
        assign row_y = (ymod == 2'(r));
        assign col_x = (xpar == 1'(c));

        always_comb begin
          if (in_cp && row_y && !col_x) begin
            ra = a_w;
          end else if (in_cp && (nmod == 2'(r)) && col_x) begin
            ra = a_n;
          end else if (in_cp && (smod == 2'(r)) && col_x) begin
            ra = a_s;
          end else begin
            ra = a_c;
          end
        end

        assign we = issue && cmd_ctrl_i.wr && !in_cp && row_y && col_x;

        dst3_ram #(
          .WIDTH(DATA_W),
          .DEPTH(BDEPTH)
        ) u_ram (
          .clk_i     (clk_i),
          .we_i      (we),
          .waddr_i   (a_c),
          .wdata_i   (cmd_value_i),
          .raddr_a_i (ra),
          .rdata_a_o (rd_a[p][r][c]),
          .raddr_b_i (a_e),
          .rdata_b_o (rd_b[p][r][c])
        );
      end
    end
  end

  // ---------------- stage 1: operand select and multiply
  logic                     s1_vld_q, s1_last_q;
  logic                     s1_top_q, s1_bot_q, s1_cp_q, s1_xp_q;
  logic                     s1_eok_q, s1_wok_q, s1_nok_q, s1_sok_q;
  logic [1:0]               s1_ym_q, s1_nm_q, s1_sm_q;
  logic [DATA_W-1:0]        s1_val_q;
  logic signed [DATA_W-1:0] opnd [NUM_COEF];
  logic signed [DATA_W-1:0] v_c;

  always_ff @(posedge clk_i) begin
    s1_top_q <= cmd_ctrl_i.has_top;
    s1_bot_q <= cmd_ctrl_i.has_bot;
    s1_cp_q  <= cmd_ctrl_i.cplane;
    s1_xp_q  <= xpar;
    s1_ym_q  <= ymod;
    s1_nm_q  <= nmod;
    s1_sm_q  <= smod;
    s1_eok_q <= (cmd_x_i != XW'(ROW_LEN - 1));
    s1_wok_q <= (cmd_x_i != '0);
    s1_nok_q <= (cmd_y_i != '0);
    s1_sok_q <= ((RW'(cmd_y_i) + RW'(1)) < cmd_rows_i);
    s1_val_q <= cmd_value_i;
  end

  always_comb begin
    v_c              = rd_a[s1_cp_q][s1_ym_q][s1_xp_q];
    opnd[CFG_COEF_C] = v_c;
    opnd[CFG_COEF_E] = s1_eok_q ? rd_b[s1_cp_q][s1_ym_q][~s1_xp_q] : v_c;
    opnd[CFG_COEF_W] = s1_wok_q ? rd_a[s1_cp_q][s1_ym_q][~s1_xp_q] : v_c;
    opnd[CFG_COEF_N] = s1_nok_q ? rd_a[s1_cp_q][s1_nm_q][s1_xp_q] : v_c;
    opnd[CFG_COEF_S] = s1_sok_q ? rd_a[s1_cp_q][s1_sm_q][s1_xp_q] : v_c;
    opnd[CFG_COEF_T] = s1_top_q ? s1_val_q : v_c;
    opnd[CFG_COEF_B] = s1_bot_q ? rd_a[~s1_cp_q][s1_ym_q][s1_xp_q] : v_c;
  end

  // ---------------- stages 2..4: products, rounding, partial sums
  logic                       s2_vld_q, s2_last_q, s3_vld_q, s3_last_q, s4_vld_q, s4_last_q;
  logic signed [2*DATA_W-1:0] s2_prod_q [NUM_COEF];
  logic signed [RNDW-1:0]     s3_rnd_q [NUM_COEF];
  logic signed [PRW-1:0]      s4_part_q [4];
  logic signed [2*DATA_W-1:0] biased [NUM_COEF];
  logic signed [TOTW-1:0]     total;
  logic [DATA_W-1:0]          sat;

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      biased[k] = s2_prod_q[k] + (64'sd1 <<< (Q_FRAC - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_COEF; k++) begin
      s2_prod_q[k] <= opnd[k] * coef_i[k];
      s3_rnd_q[k]  <= RNDW'(biased[k] >>> Q_FRAC);
    end
    s4_part_q[0] <= PRW'(s3_rnd_q[0]) + PRW'(s3_rnd_q[1]);
    s4_part_q[1] <= PRW'(s3_rnd_q[2]) + PRW'(s3_rnd_q[3]);
    s4_part_q[2] <= PRW'(s3_rnd_q[4]) + PRW'(s3_rnd_q[5]);
    s4_part_q[3] <= PRW'(s3_rnd_q[6]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s3_vld_q  <= 1'b0;
      s3_last_q <= 1'b0;
      s4_vld_q  <= 1'b0;
      s4_last_q <= 1'b0;
      credit_q  <= '0;
    end else begin
      s1_vld_q  <= issue && cmd_ctrl_i.res;
      s1_last_q <= cmd_ctrl_i.last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      s3_vld_q  <= s2_vld_q;
      s3_last_q <= s2_last_q;
      s4_vld_q  <= s3_vld_q;
      s4_last_q <= s3_last_q;
      credit_q  <= credit_d;
    end
  end

  // ---------------- stage 5: final sum, saturate, enqueue
  always_comb begin
    total = TOTW'(s4_part_q[0]) + TOTW'(s4_part_q[1])
          + TOTW'(s4_part_q[2]) + TOTW'(s4_part_q[3]);
    if (total > TOTW'(64'sh7FFF_FFFF)) begin
      sat = 32'h7FFF_FFFF;
    end else if (total < -TOTW'(64'sh8000_0000)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = total[DATA_W-1:0];
    end
  end

  // A credit is held from issue of a result until its output transfer
  always_comb begin
    credit_d = credit_q;
    if (issue && cmd_ctrl_i.res && !out_fire) begin
      credit_d = credit_q + CRW'(1);
    end else if (out_fire && !(issue && cmd_ctrl_i.res)) begin
      credit_d = credit_q - CRW'(1);
    end
  end

  logic [DATA_W:0] out_data;

  dst3_fifo #(
    .WIDTH(DATA_W + 1),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s4_vld_q),
    .push_ready_o (),
    .push_data_i  ({s4_last_q, sat}),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_data)
  );

  assign out_fire    = out_valid_o && out_ready_i;
  assign out_value_o = out_data[DATA_W-1:0];
  assign out_last_o  = out_data[DATA_W];

endmodule

>>> design/diffusion_stencil_3d_core.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_3d_core
// Seven-point 3D diffusion stencil, one sweep, streaming in and out.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, push or drain. The plane store is split into
// twelve banks (two planes, row mod 3, column parity), each with two read ports,
// so the six neighbor reads and the store write of one voxel issue in a single
// cycle. A result passes the registered datapath and the output queue; eight
// output credits cover results in flight, so the input only stalls when the
// result side stalls. The store has no reset and needs no clearing. The user must
// write coefficients and the row count only while the block is idle (unchecked).
module diffusion_stencil_3d_core
  import dst3_pkg::*;
#(
  parameter int ROW_LEN  = ROW_LEN_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,  // [31:0] sample
  input  logic                 s_axis_tuser,  // [0] opcode
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,  // [31:0] new_value
  output logic                 m_axis_tlast
);

  localparam int XW   = $clog2(ROW_LEN);
  localparam int YW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int QW   = CTRL_W + XW + YW + RW + DATA_W;

  logic signed [DATA_W-1:0] coef_q [NUM_COEF];
  logic [ROWS_W-1:0]        rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= '0;
      end
      rows_q <= ROWS_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_idx_i) == CFG_ROWS) begin
        rows_q <= cfg_data_i[ROWS_W-1:0];
      end else begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // front end -> command queue
  logic              fe_valid, q_in_ready;
  cmd_ctrl_t         fe_ctrl;
  logic [XW-1:0]     fe_x;
  logic [YW-1:0]     fe_y;
  logic [RW-1:0]     fe_rows;
  logic [DATA_W-1:0] fe_value;

  dst3_front #(
    .ROW_LEN  (ROW_LEN),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_cfg_i  (rows_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_sample_i (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (q_in_ready),
    .cmd_ctrl_o  (fe_ctrl),
    .cmd_x_o     (fe_x),
    .cmd_y_o     (fe_y),
    .cmd_rows_o  (fe_rows),
    .cmd_value_o (fe_value)
  );

  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;
  cmd_ctrl_t     be_ctrl;
  logic [XW-1:0] be_x;
  logic [YW-1:0] be_y;
  logic [RW-1:0] be_rows;
  logic [DATA_W-1:0] be_value;

  dst3_fifo #(
    .WIDTH(QW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (q_in_ready),
    .push_data_i  ({fe_ctrl, fe_x, fe_y, fe_rows, fe_value}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {be_ctrl, be_x, be_y, be_rows, be_value} = q_data;

  dst3_back #(
    .ROW_LEN  (ROW_LEN),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_ctrl_i  (be_ctrl),
    .cmd_x_i     (be_x),
    .cmd_y_i     (be_y),
    .cmd_rows_i  (be_rows),
    .cmd_value_i (be_value),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // A command is never produced while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_valid |-> q_in_ready)
    else $error("command produced while queue full");

  // The sweep-closing command is a drain that carries a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_valid && fe_ctrl.last) |-> (fe_ctrl.res && !fe_ctrl.wr))
    else $error("final command is not a result-bearing drain");

  // Writes go to the plane opposite the centre plane, so a write always has a top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_valid && fe_ctrl.wr) |-> fe_ctrl.has_top)
    else $error("store write without top neighbor");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seven-point 3D diffusion stencil core. Streams
// volumes of voxels plus drains under several coefficient and row settings,
// predicts every swept voxel in a scoreboard and compares the output stream.
// ----------------------------------------------------------------------------
module tb;
  import dst3_pkg::*;

  localparam int ROW_LEN    = ROW_LEN_DEF;
  localparam int MAX_ROWS   = MAX_ROWS_DEF;
  localparam int PLANE_W    = ROW_LEN * MAX_ROWS;
  localparam int SETTLE     = 24;
  localparam int STALL_LIM  = 5000;
  localparam int HOLD_LEN   = 400;
  localparam int ITEM_GOAL  = 400;

  class stencil_scoreboard;
    bit signed [DATA_W-1:0] store [2*PLANE_W];
    bit signed [DATA_W-1:0] coef [NUM_COEF];
    int unsigned rows_cfg, col, row, planes_done, pending;
    bit draining, parity;
    logic [DATA_W-1:0] exp_value [$];
    bit exp_last [$];
    int errors, results;

    function new();
      foreach (store[i]) store[i] = '0;
      foreach (coef[i]) coef[i] = '0;
      rows_cfg = MAX_ROWS;
      col = 0; row = 0; planes_done = 0; pending = 0;
      draining = 0; parity = 0; errors = 0; results = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [DATA_W-1:0] v);
      if (idx == CFG_ROWS) rows_cfg = v[ROWS_W-1:0];
      else coef[idx] = v;
    endfunction

    function longint rd(bit p, int unsigned x, int unsigned y);
      return longint'(store[p*PLANE_W + y*ROW_LEN + x]);
    endfunction

    // Q1.30 product rounded to nearest, ties up
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b + 64'sd536870912;
      return p >>> Q_FRAC;
    endfunction

    function logic [DATA_W-1:0] sweep(bit p, int unsigned x, int unsigned y,
                                      int unsigned rows, bit has_top, longint top,
                                      bit has_bot, longint bot);
      longint c, e, w, n, s, t, b, sum;
      c = rd(p, x, y);
      e = (x + 1 < ROW_LEN) ? rd(p, x + 1, y) : c;
      w = (x > 0) ? rd(p, x - 1, y) : c;
      n = (y > 0) ? rd(p, x, y - 1) : c;
      s = (y + 1 < rows) ? rd(p, x, y + 1) : c;
      t = has_top ? top : c;
      b = has_bot ? bot : c;
      sum = qmul(coef[CFG_COEF_C], c) + qmul(coef[CFG_COEF_E], e)
          + qmul(coef[CFG_COEF_W], w) + qmul(coef[CFG_COEF_N], n)
          + qmul(coef[CFG_COEF_S], s) + qmul(coef[CFG_COEF_T], t)
          + qmul(coef[CFG_COEF_B], b);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[DATA_W-1:0];
    endfunction

    // Step the raster position; returns 1 at the end of a plane
    function bit step_raster(int unsigned rows);
      if (col + 1 < ROW_LEN) begin
        col++;
        return 0;
      end
      col = 0;
      if (row + 1 < rows) begin
        row++;
        return 0;
      end
      row = 0;
      return 1;
    endfunction

    function void note_input(op_e op, logic [DATA_W-1:0] sample, bit last);
      int unsigned rows, x, y;
      bit plane_end;
      longint bot;
      rows = (rows_cfg < 1) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      if (row >= rows) row = rows - 1;
      x = col;
      y = row;
      if (op == OP_PUSH) begin
        if (draining) return;
        if (planes_done >= 1) begin
          bot = rd(parity, x, y);
          exp_value.push_back(sweep(!parity, x, y, rows, 1, longint'($signed(sample)),
                                    planes_done >= 2, bot));
          exp_last.push_back(0);
        end
        store[parity*PLANE_W + y*ROW_LEN + x] = sample;
        plane_end = step_raster(rows);
        if (plane_end) begin
          if (last) begin
            draining = 1;
            pending = rows * ROW_LEN;
          end else begin
            if (planes_done < 2) planes_done++;
            parity = !parity;
          end
        end
      end else begin
        if (!draining || pending == 0) return;
        bot = (planes_done >= 1) ? rd(!parity, x, y) : 0;
        exp_value.push_back(sweep(parity, x, y, rows, 0, 0, planes_done >= 1, bot));
        pending--;
        plane_end = step_raster(rows);
        if (plane_end || pending == 0) begin
          exp_last.push_back(1);
          draining = 0; pending = 0; planes_done = 0; parity = 0;
          col = 0; row = 0;
        end else begin
          exp_last.push_back(0);
        end
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] value, bit last);
      logic [DATA_W-1:0] ev;
      bit el;
      results++;
      if (exp_value.size() == 0) begin
        $display("%0t: unexpected result value=%h last=%b", $time, value, last);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      el = exp_last.pop_front();
      if (value !== ev) begin
        $display("%0t: new_value mismatch expected=%h actual=%h", $time, ev, value);
        errors++;
      end
      if (last !== el) begin
        $display("%0t: last_result mismatch expected=%b actual=%b", $time, el, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;  // [31:0] sample
  logic                 s_axis_tuser = 1'b0;  // [0] opcode
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;  // [31:0] new_value
  logic                 m_axis_tlast;

  stencil_scoreboard sb = new();
  int  burst_left = 0;
  int  idle_cycles = 0;
  int  voxels_sent = 0;
  int  items_sent = 0;
  int  volumes = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  rx_mode = 0;
  int  rx_cyc = 0;

  diffusion_stencil_3d_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitors and watchdog
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note_input(op_e'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall pattern picked at random from four modes; long hold-off on request
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= rx_cyc[0];
      endcase
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(op_e op, logic [DATA_W-1:0] data, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Wait for every expected result, then let the pipeline go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.exp_value.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [DATA_W-1:0] coefs [NUM_COEF], logic [DATA_W-1:0] rows);
    cfg_we_i <= 1'b1;
    for (int i = 0; i <= NUM_COEF; i++) begin
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= (i == CFG_ROWS) ? rows : coefs[i];
      sb.set_reg(cfg_idx_e'(i), (i == CFG_ROWS) ? rows : coefs[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One volume; noise drains, stray marks and pushes while draining are ignored.
  // With hold set, a long output hold-off is requested at the first drain.
  task automatic run_volume(int planes, int unsigned rows_eff, bit noisy, bit hold);
    int per_plane;
    bit at_end;
    per_plane = rows_eff * ROW_LEN;
    for (int p = 0; p < planes; p++) begin
      for (int v = 0; v < per_plane; v++) begin
        if (noisy && $urandom_range(0, 19) == 0) send_item(OP_DRAIN, $urandom, $urandom);
        at_end = (v == per_plane - 1);
        send_item(OP_PUSH, pick_value(),
                  at_end ? (p == planes - 1) : (noisy && $urandom_range(0, 29) == 0));
        voxels_sent++;
      end
    end
    for (int d = 0; d < per_plane; d++) begin
      if (hold && d == 0) hold_req = 1;
      if (noisy && $urandom_range(0, 19) == 0) send_item(OP_PUSH, $urandom, $urandom);
      send_item(OP_DRAIN, $urandom, $urandom);
    end
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(OP_DRAIN, $urandom, 1'b0);
    volumes++;
    settle();
  endtask

  initial begin
    logic [DATA_W-1:0] cf [NUM_COEF];
    logic [DATA_W-1:0] rows;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturating weights, zero rows acting as one, single plane
    foreach (cf[i]) cf[i] = 32'h7FFF_FFFF;
    write_regs(cf, 0);
    run_volume(1, 1, 0, 0);
    // Most negative weights, two planes with marks and noise; hold the output
    // while draining so the block fills up and stalls its input
    foreach (cf[i]) cf[i] = 32'h8000_0000;
    write_regs(cf, 1);
    run_volume(2, 1, 1, 1);

    // Random volumes, small
    while (items_sent < ITEM_GOAL) begin
      foreach (cf[i]) cf[i] = ($urandom_range(0, 3) == 0) ? pick_value()
                                : $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
      rows = $urandom_range(1, 2);
      write_regs(cf, rows);
      run_volume($urandom_range(1, 2), rows, 1, 0);
    end

    $display("Covered %0d volumes, %0d items (%0d voxels), %0d results checked,",
             volumes, items_sent, voxels_sent, sb.results);
    $display("with edge weights, stray marks, ignored items and a long output hold-off.");
    if (sb.errors == 0 && sb.exp_value.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
